@@ rtl/core/match_range_highlight_table_core_assert.svh @@
// assertion macros shared by the match range table checkers
// expects signals named clock and reset in the scope of use
`ifndef MATCH_RANGE_HIGHLIGHT_TABLE_CORE_ASSERT_SVH
`define MATCH_RANGE_HIGHLIGHT_TABLE_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define MRHT_ASSERT_NOW(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("mrht check failed");

// next-cycle implication, disabled during reset
`define MRHT_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mrht check failed");

`endif

@@ rtl/core/mrht_pkg.sv @@
// shared types and constants for the match range highlight table
// no dependencies
package mrht_pkg;

   // table size default
   localparam int MAX_RANGES_DEF = 64;

   // field widths
   localparam int KIND_W      = 3;
   localparam int LINE_W      = 16;
   localparam int COL_W       = 12;
   localparam int COL_END_W   = 13;
   localparam int IDX_OUT_W   = 6;
   localparam int HIT_W       = 2;
   localparam int CNT_OUT_W   = 7;
   localparam int ENTRY_W     = LINE_W + COL_W + COL_END_W;
   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 16;

   // operation codes
   localparam logic [KIND_W-1:0] KIND_ADD   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_NEXT  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_PREV  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_QUERY = 3'd3;
   localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd4;

   // query classes
   localparam logic [HIT_W-1:0] HIT_MISS    = 2'd0;
   localparam logic [HIT_W-1:0] HIT_MATCH   = 2'd1;
   localparam logic [HIT_W-1:0] HIT_CURRENT = 2'd2;

   // result beat, last member in the lowest bits
   typedef struct packed {
      logic [CNT_OUT_W-1:0] entry_count;
      logic [HIT_W-1:0]     hit_class;
      logic [IDX_OUT_W-1:0] entry_index;
      logic                 rejected;
   } result_type;

endpackage

@@ rtl/core/match_range_highlight_table_core.sv @@
// match range highlight table: top level
// Usage:
//   req channel carries one operation per beat, selected by req_tuser (kind):
//   add, next, prev, query or clear. Every operation returns exactly one
//   rsp beat with rejected, entry_index, hit_class and entry_count.
//   Ranges live in one ram of MAX_RANGES entries; count and cursor live in
//   flops. Operations are handled one at a time.
// Flow:
//   add, next, prev, clear, unknown kinds and a query on an empty table
//   pass from accept through the result register to the rsp register. A query
//   scans the ram one entry per cycle over its one read port, stopping at the
//   first covering range, or after the last entry on a miss. req_tready is high
//   whenever no operation is in progress, even while an earlier result waits.
// Reset:
//   synchronous, active high; empties the table and drops the cursor. Ram
//   contents are not cleared, entries at or beyond the count are never read.
// Stall:
//   a result holds in the rsp register while rsp_tready is low; a finished
//   operation waits in its own result register until the rsp register frees.
module match_range_highlight_table_core
   import mrht_pkg::*;
#(
   parameter int MAX_RANGES = MAX_RANGES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   // req_tdata: line_number[15:0], column[27:16], column_end[40:28], zero pad
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // req_tuser: kind[2:0]
   input  logic [KIND_W-1:0]      req_tuser,
   // rsp_tdata: rejected[0], entry_index[6:1], hit_class[8:7], entry_count[15:9]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int IDX_W = $clog2(MAX_RANGES);
   localparam int CNT_W = $clog2(MAX_RANGES + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_WAIT = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] cur_ff, cur_in;
   logic             curv_ff, curv_in;
   logic [LINE_W-1:0] q_line_ff, q_line_in;
   logic [COL_W-1:0]  q_col_ff, q_col_in;
   logic [CNT_W-1:0] scan_cnt_ff, scan_cnt_in;
   logic             chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0] chk_idx_ff, chk_idx_in;
   result_type       res_ff, res_in;
   logic             rsp_vld_ff, rsp_vld_in;
   result_type       rsp_data_ff, rsp_data_in;

   logic [KIND_W-1:0]    kind;
   logic [LINE_W-1:0]    in_line;
   logic [COL_W-1:0]     in_col;
   logic [COL_END_W-1:0] in_col_end;
   logic                 accept;
   logic                 full;
   logic                 cur_ok;
   logic [CNT_W-1:0]     cur_ext;
   logic [CNT_W-1:0]     cur_next;
   logic [CNT_W-1:0]     cur_prev;
   logic                 wr_en;
   logic [ENTRY_W-1:0]   wr_data;
   logic                 rd_en;
   logic [IDX_W-1:0]     rd_addr;
   logic [ENTRY_W-1:0]   rd_data;
   logic [LINE_W-1:0]    e_line;
   logic [COL_W-1:0]     e_start;
   logic [COL_END_W-1:0] e_end;
   logic                 e_hit;
   logic                 last_chk;
   logic                 load_rsp;

   // unpack request
   assign kind       = req_tuser;
   assign in_line    = req_tdata[LINE_W-1:0];
   assign in_col     = req_tdata[LINE_W +: COL_W];
   assign in_col_end = req_tdata[LINE_W + COL_W +: COL_END_W];

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   // table status and cursor moves
   assign full     = (count_ff >= CNT_W'(MAX_RANGES));
   assign cur_ext  = CNT_W'(cur_ff);
   assign cur_ok   = curv_ff && (cur_ext < count_ff);
   assign cur_next = (!cur_ok || (cur_ext + 1'b1 >= count_ff)) ? '0 : cur_ext + 1'b1;
   assign cur_prev = (!cur_ok || (cur_ff == '0)) ? count_ff - 1'b1 : cur_ext - 1'b1;

   // range storage
   assign wr_en   = accept && (kind == KIND_ADD) && !full;
   assign wr_data = {in_col_end, in_col, in_line};
   assign rd_en   = (state_ff == ST_SCAN) && (scan_cnt_ff < count_ff);
   assign rd_addr = scan_cnt_ff[IDX_W-1:0];

   mrht_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_RANGES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // compare the entry read last cycle against the query point
   assign e_line   = rd_data[LINE_W-1:0];
   assign e_start  = rd_data[LINE_W +: COL_W];
   assign e_end    = rd_data[LINE_W + COL_W +: COL_END_W];
   assign e_hit    = (e_line == q_line_ff) && (q_col_ff >= e_start)
                     && ({1'b0, q_col_ff} < e_end);
   assign last_chk = (CNT_W'(chk_idx_ff) + 1'b1 == count_ff);

   assign load_rsp = (state_ff == ST_WAIT) && (!rsp_vld_ff || rsp_tready);

   // operation sequencer
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      cur_in      = cur_ff;
      curv_in     = curv_ff;
      q_line_in   = q_line_ff;
      q_col_in    = q_col_ff;
      scan_cnt_in = scan_cnt_ff;
      chk_vld_in  = rd_en;
      chk_idx_in  = rd_addr;
      res_in      = res_ff;
      if (rd_en) begin
         scan_cnt_in = scan_cnt_ff + 1'b1;
      end
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               res_in.rejected    = 1'b0;
               res_in.entry_index = '0;
               res_in.hit_class   = HIT_MISS;
               state_in           = ST_WAIT;
               case (kind)
                  KIND_ADD: begin
                     if (full) begin
                        res_in.rejected = 1'b1;
                     end else begin
                        res_in.entry_index = IDX_OUT_W'(count_ff);
                        count_in           = count_ff + 1'b1;
                        if (!curv_ff) begin
                           curv_in = 1'b1;
                           cur_in  = '0;
                        end
                     end
                  end
                  KIND_NEXT, KIND_PREV: begin
                     if (count_ff == '0) begin
                        res_in.rejected = 1'b1;
                     end else begin
                        curv_in = 1'b1;
                        if (kind == KIND_NEXT) begin
                           cur_in             = cur_next[IDX_W-1:0];
                           res_in.entry_index = IDX_OUT_W'(cur_next);
                        end else begin
                           cur_in             = cur_prev[IDX_W-1:0];
                           res_in.entry_index = IDX_OUT_W'(cur_prev);
                        end
                     end
                  end
                  KIND_QUERY: begin
                     q_line_in   = in_line;
                     q_col_in    = in_col;
                     scan_cnt_in = '0;
                     if (count_ff != '0) begin
                        state_in = ST_SCAN;
                     end
                  end
                  KIND_CLEAR: begin
                     count_in = '0;
                     cur_in   = '0;
                     curv_in  = 1'b0;
                  end
                  default: begin
                  end
               endcase
               res_in.entry_count = CNT_OUT_W'(count_in);
            end
         end
         ST_SCAN: begin
            if (chk_vld_ff) begin
               if (e_hit) begin
                  res_in.hit_class = (curv_ff && (cur_ff == chk_idx_ff)) ?
                                     HIT_CURRENT : HIT_MATCH;
                  state_in = ST_WAIT;
               end else if (last_chk) begin
                  state_in = ST_WAIT;
               end
            end
         end
         ST_WAIT: begin
            if (load_rsp) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_vld_in  = rsp_vld_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      if (load_rsp) begin
         rsp_vld_in  = 1'b1;
         rsp_data_in = res_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         cur_ff     <= '0;
         curv_ff    <= 1'b0;
         chk_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         cur_ff     <= cur_in;
         curv_ff    <= curv_in;
         chk_vld_ff <= chk_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      q_line_ff   <= q_line_in;
      q_col_ff    <= q_col_in;
      scan_cnt_ff <= scan_cnt_in;
      chk_idx_ff  <= chk_idx_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = RSP_TDATA_W'(rsp_data_ff);

endmodule

@@ rtl/core/mrht_ram.sv @@
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module mrht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/mrht_chk.sv @@
// port-level checks for the match range highlight table
// depends on mrht_pkg and the assertion macro header; bound to the top level
`include "match_range_highlight_table_core_assert.svh"

module mrht_chk
   import mrht_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   // a stalled result beat holds
   `MRHT_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // one operation at a time: busy right after an accepted beat
   `MRHT_ASSERT_NEXT(a_busy_after_accept, req_tvalid && req_tready, !req_tready)

   // hit class is one of the three defined classes
   `MRHT_ASSERT_NOW(a_hit_code, rsp_tvalid, rsp_tdata[8:7] <= HIT_CURRENT)

   // a rejected operation reports no index and no hit
   `MRHT_ASSERT_NOW(a_rej_clean, rsp_tvalid && rsp_tdata[0], rsp_tdata[8:1] == 8'd0)

   // a hit needs a nonempty table
   `MRHT_ASSERT_NOW(a_hit_count, rsp_tvalid && rsp_tdata[8:7] != HIT_MISS, rsp_tdata[15:9] != 7'd0)

endmodule

bind match_range_highlight_table_core mrht_chk u_mrht_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
